>>> src/gfp_pkg.sv
package gfp_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgHeader  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTrailer = 2'd1;

  // Reset values of the configuration registers
  localparam logic [7:0] HeaderReset  = 8'hA5;
  localparam logic [7:0] TrailerReset = 8'hA6;

  // Frame layout
  localparam int unsigned PosW       = 5;
  localparam logic [PosW-1:0] PosHunt = 5'd0;
  localparam logic [PosW-1:0] PosLast = 5'd17;
  localparam int unsigned StoreDepth = 16;
  localparam int unsigned StoreIdxW  = $clog2(StoreDepth);
  localparam int unsigned AxisCount  = 6;

  // Classified word passed from the front end to the back end
  typedef struct packed {
    logic                 is_trailer;
    logic                 trailer_ok;
    logic [StoreIdxW-1:0] idx;
    logic [7:0]           data;
  } gfp_entry_t;

endpackage

>>> src/gfp_front.sv
module gfp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gfp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [7:0]                    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    rx_byte_i,
  output logic                          push_o,
  output gfp_pkg::gfp_entry_t           entry_o,
  input  logic                          q_full_i
);

  logic [7:0]               header_q;
  logic [7:0]               trailer_q;
  logic [gfp_pkg::PosW-1:0] pos_q, pos_d;
  logic                     accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q  <= gfp_pkg::HeaderReset;
      trailer_q <= gfp_pkg::TrailerReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == gfp_pkg::CfgHeader) begin
        header_q <= cfg_data_i;
      end else if (cfg_idx_i == gfp_pkg::CfgTrailer) begin
        trailer_q <= cfg_data_i;
      end
    end
  end

  // Classify the word by frame position
  always_comb begin
    pos_d              = pos_q;
    push_o             = 1'b0;
    entry_o.is_trailer = 1'b0;
    entry_o.trailer_ok = (rx_byte_i == trailer_q);
    entry_o.idx        = gfp_pkg::StoreIdxW'(pos_q - 5'd1);
    entry_o.data       = rx_byte_i;
    if (accept) begin
      if (pos_q == gfp_pkg::PosHunt || pos_q > gfp_pkg::PosLast) begin
        // hunting: out-of-range positions behave the same
        pos_d = (rx_byte_i == header_q) ? 5'd1 : gfp_pkg::PosHunt;
      end else if (pos_q < gfp_pkg::PosLast) begin
        push_o = 1'b1;
        pos_d  = pos_q + 5'd1;
      end else begin
        push_o             = 1'b1;
        entry_o.is_trailer = 1'b1;
        pos_d              = gfp_pkg::PosHunt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= gfp_pkg::PosHunt;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

>>> src/gfp_queue.sv
module gfp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  gfp_pkg::gfp_entry_t entry_i,
  output logic                full_o,
  output logic                valid_o,
  output gfp_pkg::gfp_entry_t entry_o,
  input  logic                pop_i
);

  // Two-entry FIFO
  gfp_pkg::gfp_entry_t mem_q [2];
  logic                wr_ptr_q, rd_ptr_q;
  logic [1:0]          count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> src/gfp_back.sv
module gfp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  gfp_pkg::gfp_entry_t q_entry_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [15:0]         axes_o [gfp_pkg::AxisCount],
  output logic [7:0]          combo_code_o,
  output logic [11:0]         button_bits_o,
  output logic                frame_error_o
);

  logic [7:0]  store_q [gfp_pkg::StoreDepth];
  logic [15:0] held_axes_q [gfp_pkg::AxisCount];
  logic [7:0]  held_combo_q;
  logic [11:0] held_buttons_q;
  logic [15:0] dec_axes [gfp_pkg::AxisCount];
  logic [11:0] dec_buttons;
  logic [15:0] out_axes_q [gfp_pkg::AxisCount];
  logic [7:0]  out_combo_q;
  logic [11:0] out_buttons_q;
  logic        out_err_q;
  logic        out_valid_q;
  logic        fire_trailer;
  logic        good;

  // A trailer word may only leave the queue when the output slot is free
  assign pop_o = q_valid_i &&
                 (!q_entry_i.is_trailer || !out_valid_q || !out_stall_i);
  assign fire_trailer = pop_o && q_entry_i.is_trailer;
  assign good         = q_entry_i.trailer_ok;

  // Frame byte store
  always_ff @(posedge clk_i) begin
    if (pop_o && !q_entry_i.is_trailer) begin
      store_q[q_entry_i.idx] <= q_entry_i.data;
    end
  end

  // Decode of the stored frame, little-endian axes
  always_comb begin
    for (int i = 0; i < gfp_pkg::AxisCount; i++) begin
      dec_axes[i] = {store_q[2*i+1], store_q[2*i]};
    end
    dec_buttons = {store_q[15][0],
                   store_q[14][6], store_q[14][5], store_q[14][4],
                   store_q[14][3], store_q[14][2],
                   store_q[13][7], store_q[13][6], store_q[13][4],
                   store_q[13][3], store_q[13][1], store_q[13][0]};
  end

  // Held values from the last good frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < gfp_pkg::AxisCount; i++) begin
        held_axes_q[i] <= 16'd0;
      end
      held_combo_q   <= 8'd0;
      held_buttons_q <= 12'd0;
    end else if (fire_trailer && good) begin
      held_axes_q    <= dec_axes;
      held_combo_q   <= store_q[12];
      held_buttons_q <= dec_buttons;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (fire_trailer) begin
      for (int i = 0; i < gfp_pkg::AxisCount; i++) begin
        out_axes_q[i] <= good ? dec_axes[i] : held_axes_q[i];
      end
      out_combo_q   <= good ? store_q[12] : held_combo_q;
      out_buttons_q <= good ? dec_buttons : held_buttons_q;
      out_err_q     <= !good;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire_trailer) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign axes_o        = out_axes_q;
  assign combo_code_o  = out_combo_q;
  assign button_bits_o = out_buttons_q;
  assign frame_error_o = out_err_q;

endmodule

>>> src/gamepad_frame_parser_top.sv
// Gamepad frame parser.
// Input channel: one received serial byte per word on rx_byte_i, taken when
// in_valid_i is high and in_stall_o is low. Bytes are skipped until one equals
// the header register; the next 16 bytes are stored and the 17th is checked
// against the trailer register. Output channel: one word per frame, taken
// when out_valid_o is high and out_stall_i is low. A good trailer gives the
// freshly decoded axes, combo byte and buttons with frame_error_o clear; a bad
// one repeats the last good values with frame_error_o set.
// Throughput: one byte per cycle while in_stall_o is low. The result word for a
// frame passes from the edge that takes the trailer byte through the two-word
// queue into the back-end output register, which drives out_valid_o.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 header, 1 trailer); other indexes are ignored.
// Reset: hunting for a header, header 0xA5, trailer 0xA6, held values zero,
// no output pending. When the receiver stalls the output word holds; body
// bytes still drain into the store until the next trailer word reaches the
// queue head, then the queue fills and in_stall_o rises.
module gamepad_frame_parser_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gfp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]                  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [15:0]                 left_stick_x_o,
  output logic [15:0]                 left_stick_y_o,
  output logic [15:0]                 right_stick_x_o,
  output logic [15:0]                 right_stick_y_o,
  output logic [15:0]                 left_trigger_travel_o,
  output logic [15:0]                 right_trigger_travel_o,
  output logic [7:0]                  combo_code_o,
  output logic [11:0]                 button_bits_o,
  output logic                        frame_error_o
);

  gfp_pkg::gfp_entry_t push_entry, q_entry;
  logic                push, q_full, q_valid, pop;
  logic [15:0]         axes [gfp_pkg::AxisCount];

  gfp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .push_o     (push),
    .entry_o    (push_entry),
    .q_full_i   (q_full)
  );

  gfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (q_entry),
    .pop_i   (pop)
  );

  gfp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .axes_o        (axes),
    .combo_code_o  (combo_code_o),
    .button_bits_o (button_bits_o),
    .frame_error_o (frame_error_o)
  );

  assign left_stick_x_o         = axes[0];
  assign left_stick_y_o         = axes[1];
  assign right_stick_x_o        = axes[2];
  assign right_stick_y_o        = axes[3];
  assign left_trigger_travel_o  = axes[4];
  assign right_trigger_travel_o = axes[5];

endmodule

>>> test/gfp_frame_checker.sv
// Frame checker: follows the byte and report channels of the parser, keeps its
// own copy of the parser state and compares every report word with the oldest
// expected one.
module gfp_frame_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gfp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]                  cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [7:0]                  rx_byte_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [15:0]                 left_stick_x_i,
  input  logic [15:0]                 left_stick_y_i,
  input  logic [15:0]                 right_stick_x_i,
  input  logic [15:0]                 right_stick_y_i,
  input  logic [15:0]                 left_trigger_travel_i,
  input  logic [15:0]                 right_trigger_travel_i,
  input  logic [7:0]                  combo_code_i,
  input  logic [11:0]                 button_bits_i,
  input  logic                        frame_error_i,
  output int unsigned                 mismatches_o,
  output int unsigned                 pending_o,
  output int unsigned                 reports_o,
  output int unsigned                 flagged_o
);

  typedef struct packed {
    logic [15:0] left_x;
    logic [15:0] left_y;
    logic [15:0] right_x;
    logic [15:0] right_y;
    logic [15:0] left_trig;
    logic [15:0] right_trig;
    logic [7:0]  combo;
    logic [11:0] buttons;
    logic        err;
  } pad_report_t;

  // Shadow of the parser registers and state
  logic [7:0]               header_reg  = gfp_pkg::HeaderReset;
  logic [7:0]               trailer_reg = gfp_pkg::TrailerReset;
  logic [gfp_pkg::PosW-1:0] frame_pos   = gfp_pkg::PosHunt;
  logic [7:0]               frame_bytes [gfp_pkg::StoreDepth];
  pad_report_t              held_report = '0;

  pad_report_t expected_reports [$];
  int unsigned mismatch_count = 0;
  int unsigned report_count   = 0;
  int unsigned flag_count     = 0;

  task automatic check_field(input string label, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    pad_report_t want_rpt;
    logic        good;
    if (!rst_ni) begin
      header_reg  = gfp_pkg::HeaderReset;
      trailer_reg = gfp_pkg::TrailerReset;
      frame_pos   = gfp_pkg::PosHunt;
      held_report = '0;
      expected_reports.delete();
    end else begin
      // prediction: one accepted byte word
      if (in_valid_i && !in_stall_i) begin
        if (frame_pos == gfp_pkg::PosHunt || frame_pos > gfp_pkg::PosLast) begin
          frame_pos = (rx_byte_i == header_reg) ? gfp_pkg::PosHunt + 1'b1
                                                : gfp_pkg::PosHunt;
        end else if (frame_pos < gfp_pkg::PosLast) begin
          frame_bytes[gfp_pkg::StoreIdxW'(frame_pos - 1'b1)] = rx_byte_i;
          frame_pos = frame_pos + 1'b1;
        end else begin
          // trailer position: decode on a match, else repeat the held values
          good = (rx_byte_i == trailer_reg);
          if (good) begin
            held_report.left_x     = {frame_bytes[1],  frame_bytes[0]};
            held_report.left_y     = {frame_bytes[3],  frame_bytes[2]};
            held_report.right_x    = {frame_bytes[5],  frame_bytes[4]};
            held_report.right_y    = {frame_bytes[7],  frame_bytes[6]};
            held_report.left_trig  = {frame_bytes[9],  frame_bytes[8]};
            held_report.right_trig = {frame_bytes[11], frame_bytes[10]};
            held_report.combo      = frame_bytes[12];
            held_report.buttons    = {frame_bytes[15][0], frame_bytes[14][6],
                                      frame_bytes[14][5], frame_bytes[14][4],
                                      frame_bytes[14][3], frame_bytes[14][2],
                                      frame_bytes[13][7], frame_bytes[13][6],
                                      frame_bytes[13][4], frame_bytes[13][3],
                                      frame_bytes[13][1], frame_bytes[13][0]};
          end
          want_rpt     = held_report;
          want_rpt.err = !good;
          expected_reports.push_back(want_rpt);
          frame_pos = gfp_pkg::PosHunt;
        end
      end

      // comparison: one accepted report word
      if (out_valid_i && !out_stall_i) begin
        report_count++;
        if (frame_error_i) flag_count++;
        if (expected_reports.size() == 0) begin
          $display("%0t: report word mismatch, expected none, actual err %b lx %h",
                   $time, frame_error_i, left_stick_x_i);
          mismatch_count++;
        end else begin
          want_rpt = expected_reports.pop_front();
          check_field("left_stick_x",         want_rpt.left_x,     left_stick_x_i);
          check_field("left_stick_y",         want_rpt.left_y,     left_stick_y_i);
          check_field("right_stick_x",        want_rpt.right_x,    right_stick_x_i);
          check_field("right_stick_y",        want_rpt.right_y,    right_stick_y_i);
          check_field("left_trigger_travel",  want_rpt.left_trig,  left_trigger_travel_i);
          check_field("right_trigger_travel", want_rpt.right_trig, right_trigger_travel_i);
          check_field("combo_code",           16'(want_rpt.combo),   16'(combo_code_i));
          check_field("button_bits",          16'(want_rpt.buttons), 16'(button_bits_i));
          check_field("frame_error",          16'(want_rpt.err),     16'(frame_error_i));
        end
      end

      // register writes apply from the next byte on
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gfp_pkg::CfgHeader:  header_reg  = cfg_data_i;
          gfp_pkg::CfgTrailer: trailer_reg = cfg_data_i;
          default: ;
        endcase
      end
    end
    mismatches_o <= mismatch_count;
    pending_o    <= expected_reports.size();
    reports_o    <= report_count;
    flagged_o    <= flag_count;
  end

endmodule

>>> test/gamepad_frame_parser_top_tb.sv
module gamepad_frame_parser_top_tb;

  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned HoldCycles   = 200;
  localparam int unsigned MaxGap       = 10;
  localparam int unsigned PhaseCount   = 5;
  localparam int unsigned PhaseBytes   = 220;
  localparam longint      TimeoutTime  = 64'd2_400_000;
  // indexes with no register behind them
  localparam logic [gfp_pkg::CfgIdxW-1:0] CfgSpare2 = 2'd2;
  localparam logic [gfp_pkg::CfgIdxW-1:0] CfgSpare3 = 2'd3;

  logic                        clk_i      = 1'b0;
  logic                        rst_ni     = 1'b0;
  logic                        cfg_we_i   = 1'b0;
  logic [gfp_pkg::CfgIdxW-1:0] cfg_idx_i  = gfp_pkg::CfgHeader;
  logic [7:0]                  cfg_data_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [7:0]                  rx_byte_i  = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [15:0] left_stick_x_o, left_stick_y_o, right_stick_x_o, right_stick_y_o;
  logic [15:0] left_trigger_travel_o, right_trigger_travel_o;
  logic [7:0]  combo_code_o;
  logic [11:0] button_bits_o;
  logic        frame_error_o;

  int unsigned fail_count, pending, reports, flagged;

  // stimulus state
  logic [7:0]  cur_header    = gfp_pkg::HeaderReset;
  logic [7:0]  cur_trailer   = gfp_pkg::TrailerReset;
  bit          src_idle      = 1'b1;
  bit          sink_idle     = 1'b1;
  int unsigned hold_requests = 0;
  int unsigned holds_done    = 0;
  int unsigned bytes_sent    = 0;
  int unsigned settings_used = 1;

  gamepad_frame_parser_top DUT (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .rx_byte_i             (rx_byte_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .left_stick_x_o        (left_stick_x_o),
    .left_stick_y_o        (left_stick_y_o),
    .right_stick_x_o       (right_stick_x_o),
    .right_stick_y_o       (right_stick_y_o),
    .left_trigger_travel_o (left_trigger_travel_o),
    .right_trigger_travel_o(right_trigger_travel_o),
    .combo_code_o          (combo_code_o),
    .button_bits_o         (button_bits_o),
    .frame_error_o         (frame_error_o)
  );

  gfp_frame_checker u_checker (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .in_valid_i            (in_valid_i),
    .in_stall_i            (in_stall_o),
    .rx_byte_i             (rx_byte_i),
    .out_valid_i           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .left_stick_x_i        (left_stick_x_o),
    .left_stick_y_i        (left_stick_y_o),
    .right_stick_x_i       (right_stick_x_o),
    .right_stick_y_i       (right_stick_y_o),
    .left_trigger_travel_i (left_trigger_travel_o),
    .right_trigger_travel_i(right_trigger_travel_o),
    .combo_code_i          (combo_code_o),
    .button_bits_i         (button_bits_o),
    .frame_error_i         (frame_error_o),
    .mismatches_o          (fail_count),
    .pending_o             (pending),
    .reports_o             (reports),
    .flagged_o             (flagged)
  );

  always #4 clk_i = ~clk_i;

  // hard limit on run time
  initial begin
    #(TimeoutTime);
    $display("Timeout with %0d report words outstanding", pending);
    $display("Regression FAIL");
    $finish;
  end

  // receiver: random stall per word if sink_idle, plus requested long hold-offs
  initial begin : sink
    int unsigned wait_n;
    wait (rst_ni === 1'b1);
    forever begin
      if (holds_done != hold_requests) begin
        wait_n = HoldCycles;
        holds_done++;
      end else begin
        wait_n = sink_idle ? $urandom_range(0, MaxGap) : 0;
      end
      if (wait_n != 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // one byte word, after a random gap if src_idle; valid stays up with no gap
  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, MaxGap) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic push_noise(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_byte(8'($urandom));
  endtask

  // header, 16 body bytes (byte 1 in the low bits), trailer
  task automatic push_frame(input logic [127:0] body, input logic [7:0] trl);
    push_byte(cur_header);
    for (int k = 0; k < 16; k++) push_byte(body[8*k +: 8]);
    push_byte(trl);
  endtask

  // random body, salted with header and trailer values
  function automatic logic [127:0] rand_body();
    logic [127:0] b;
    int unsigned  r;
    for (int k = 0; k < 16; k++) begin
      r = $urandom_range(0, 7);
      b[8*k +: 8] = (r == 0) ? cur_header : (r == 1) ? cur_trailer : 8'($urandom);
    end
    return b;
  endfunction

  // stop sending and let every expected report word drain out
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [gfp_pkg::CfgIdxW-1:0] idx, input logic [7:0] val);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      gfp_pkg::CfgHeader:  cur_header  = val;
      gfp_pkg::CfgTrailer: cur_trailer = val;
      default: ;
    endcase
  endtask

  // mostly well-formed frames, with cut-short frames and line noise mixed in
  task automatic run_traffic(input int unsigned budget);
    int unsigned start;
    int unsigned pick;
    logic [7:0]  flip;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        push_noise($urandom_range(0, 2));
        flip = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        push_frame(rand_body(), cur_trailer ^ flip);
      end else if (pick < 85) begin
        push_byte(cur_header);
        push_noise($urandom_range(0, 16));
      end else begin
        push_noise($urandom_range(1, 8));
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0] hdr, trl;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: line noise while hunting, then all-ones body
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(gfp_pkg::TrailerReset);
    push_frame({16{8'hFF}}, cur_trailer);
    // bad trailer that carries the header value: must not open a new frame
    push_frame({16{8'h00}}, cur_header);
    for (int i = 0; i < 17; i++) push_byte(8'h3C);
    push_byte(cur_trailer);
    // alternating bit patterns, then header values inside the body
    push_frame({8{8'h55, 8'hAA}}, cur_trailer);
    push_frame({8{8'hAA, 8'h55}}, cur_trailer);
    push_frame({16{gfp_pkg::HeaderReset}}, cur_trailer);
    // trailer register changed part way through a frame
    push_byte(cur_header);
    for (int i = 0; i < 8; i++) push_byte(8'h81);
    write_reg(gfp_pkg::CfgTrailer, 8'h00);
    settings_used++;
    for (int i = 0; i < 8; i++) push_byte(8'h7E);
    push_byte(8'h00);
    // writes to unused indexes leave both registers alone
    write_reg(CfgSpare2, 8'h00);
    write_reg(CfgSpare3, 8'hFF);
    push_frame(rand_body(), cur_trailer);

    // random phases over a range of register settings and idling styles
    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0: begin hdr = 8'h00; trl = 8'hFF; src_idle = 1'b1; sink_idle = 1'b1; end
        1: begin hdr = 8'hFF; trl = 8'h00; src_idle = 1'b0; sink_idle = 1'b0; end
        2: begin hdr = 8'h5A; trl = 8'h5A; src_idle = 1'b0; sink_idle = 1'b1; end
        3: begin
          hdr = 8'($urandom); trl = 8'($urandom); src_idle = 1'b1; sink_idle = 1'b0;
        end
        default: begin
          hdr = gfp_pkg::HeaderReset; trl = gfp_pkg::TrailerReset;
          src_idle = 1'b1; sink_idle = 1'b1;
        end
      endcase
      write_reg(gfp_pkg::CfgHeader, hdr);
      write_reg(gfp_pkg::CfgTrailer, trl);
      settings_used++;
      // back-pressure phase: receiver holds off while bytes keep coming
      if (ph == 2) hold_requests++;
      run_traffic(PhaseBytes / 2);
      settle();
      run_traffic(PhaseBytes / 2);
    end

    settle();
    $display("Sent %0d bytes over %0d register settings; %0d report words seen, %0d bad frames.",
             bytes_sent, settings_used, reports, flagged);
    $display("Included a %0d-cycle receiver hold-off and sender pauses to empty.", HoldCycles);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
